// File: sv/mcbm_pkg.sv
package mcbm_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int PRG_BANK_W  = 8;
    localparam int CHR_BANK_W  = 2;
    localparam int CFG_INDEX_W = 8;

    // Upper nibble of the register select window 0x5000-0x5FFF
    localparam logic [3:0] SELECT_PAGE = 4'h5;

    // Bus operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_MASK = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_MASK = 8'd1;

    localparam logic [PRG_BANK_W-1:0] PRG_MASK_RESET = 8'd127;
    localparam logic [CHR_BANK_W-1:0] CHR_MASK_RESET = 2'd3;

    // Register addressed by a ROM-space write
    typedef enum logic [1:0] {
        REG_CHR   = 2'd0,
        REG_INNER = 2'd1,
        REG_MODE  = 2'd2,
        REG_OUTER = 2'd3
    } reg_sel_t;

    // Banking state
    typedef struct packed {
        logic [1:0] mirror;
        logic [3:0] inner;
        logic [3:0] mode;
        logic [5:0] outer;
        logic [1:0] chr_sel;
    } bank_state_t;

    localparam bank_state_t STATE_RESET = '{
        mirror:  2'd0,
        inner:   4'hF,
        mode:    4'd0,
        outer:   6'h3F,
        chr_sel: 2'd0
    };

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] write_data;
    } bus_item_t;

    typedef struct packed {
        logic [PRG_BANK_W-1:0] prg_bank_low;
        logic [PRG_BANK_W-1:0] prg_bank_high;
        logic [CHR_BANK_W-1:0] chr_bank;
        logic [1:0]            mirror_mode;
        logic                  read_passthrough;
    } result_t;

endpackage

// File: sv/mcbm_bus_if.sv
interface mcbm_bus_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, output operation, output bus_address,
                    output write_data, input ready);
    modport sink   (input valid, input operation, input bus_address,
                    input write_data, output ready);
endinterface

// File: sv/mcbm_res_if.sv
interface mcbm_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] prg_bank_low;
    logic [7:0] prg_bank_high;
    logic [1:0] chr_bank;
    logic [1:0] mirror_mode;
    logic       read_passthrough;

    modport source (output valid, output prg_bank_low, output prg_bank_high,
                    output chr_bank, output mirror_mode, output read_passthrough,
                    input ready);
    modport sink   (input valid, input prg_bank_low, input prg_bank_high,
                    input chr_bank, input mirror_mode, input read_passthrough,
                    output ready);
endinterface

// File: sv/mcbm_cfg_if.sv
interface mcbm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/mcbm_bank_mix.sv
module mcbm_bank_mix
    import mcbm_pkg::*;
(
    input  bank_state_t           state,
    input  logic [PRG_BANK_W-1:0] prg_mask,
    input  logic [CHR_BANK_W-1:0] chr_mask,
    output logic [PRG_BANK_W-1:0] prg_low,
    output logic [PRG_BANK_W-1:0] prg_high,
    output logic [CHR_BANK_W-1:0] chr_bank
);

    // 16K bank for one window; a14 picks the window
    function automatic logic [PRG_BANK_W-1:0] window_bank(input bank_state_t st,
                                                          input logic a14);
        logic [3:0]            mode;
        logic [PRG_BANK_W-1:0] cur;
        logic [PRG_BANK_W-1:0] outer2;
        logic [PRG_BANK_W-1:0] size_mask;
        mode   = st.mode;
        outer2 = {1'b0, st.outer, 1'b0};
        // fixed window of a fixed-bank mode acts as 32K
        if ((mode[1:0] ^ {1'b0, a14}) == 2'b10)
            mode = 4'd0;
        if (!mode[1])
            cur = {3'd0, st.inner, a14};
        else
            cur = {4'd0, st.inner};
        unique case (mode[3:2])
            2'd0:    size_mask = 8'h01;
            2'd1:    size_mask = 8'h03;
            2'd2:    size_mask = 8'h07;
            default: size_mask = 8'h0F;
        endcase
        return ((cur ^ outer2) & size_mask) ^ outer2;
    endfunction

    logic [PRG_BANK_W-1:0] raw_low;
    logic [PRG_BANK_W-1:0] raw_high;

    assign raw_low  = window_bank(state, 1'b0);
    assign raw_high = window_bank(state, 1'b1);

    // bank above the ROM size wraps through the mask
    assign prg_low  = (raw_low  > prg_mask) ? (raw_low  & prg_mask) : raw_low;
    assign prg_high = (raw_high > prg_mask) ? (raw_high & prg_mask) : raw_high;
    assign chr_bank = (state.chr_sel > chr_mask) ? (state.chr_sel & chr_mask)
                                                 : state.chr_sel;

endmodule

// File: sv/multicart_bank_mapper.sv
// Multicart bank mapper: banking registers plus PRG/CHR bank mixing.
// Path: bus beat -> input register -> result register -> result beat.
// Throughput: one beat per cycle unless res stalls; update and mixing share a stage.
// Reset (rst_n low, async): pipeline empty, masks to 127/3, inner and outer banks
// all ones, select/mode/mirroring/CHR select zero. No clearing pass.
module multicart_bank_mapper
    import mcbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mcbm_bus_if.sink  bus,
    mcbm_res_if.source res,
    mcbm_cfg_if.sink  cfg
);

    // ---------------------------------------------------------------
    // Pipeline control
    // ---------------------------------------------------------------
    logic      s1_valid_reg;
    bus_item_t s1_item_reg;
    logic      out_valid_reg;
    result_t   out_reg;

    logic out_advance;
    logic s1_fire;

    // result register frees when empty or taken this cycle
    assign out_advance = !out_valid_reg || res.ready;
    assign s1_fire     = s1_valid_reg && out_advance;
    assign bus.ready   = !s1_valid_reg || out_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bus.ready)
        begin
            s1_valid_reg <= bus.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bus.valid && bus.ready)
        begin
            s1_item_reg <= '{operation:   bus.operation,
                             bus_address: bus.bus_address,
                             write_data:  bus.write_data};
        end
    end

    // ---------------------------------------------------------------
    // Configuration: ROM size masks; user writes only while idle, not enforced.
    // ---------------------------------------------------------------
    logic [PRG_BANK_W-1:0] prg_mask_reg;
    logic [CHR_BANK_W-1:0] chr_mask_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mask_reg <= PRG_MASK_RESET;
            chr_mask_reg <= CHR_MASK_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_PRG_MASK)
                prg_mask_reg <= cfg.data;
            else if (cfg.index == CFG_CHR_MASK)
                chr_mask_reg <= cfg.data[CHR_BANK_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Banking register update
    // ---------------------------------------------------------------
    bank_state_t state_reg;
    bank_state_t state_next;
    reg_sel_t    reg_select_reg;
    reg_sel_t    reg_select_next;

    logic             is_write;
    logic             in_select;
    logic             in_rom;
    logic [DATA_W-1:0] wdata;

    assign is_write  = (s1_item_reg.operation == OP_WRITE);
    assign in_select = (s1_item_reg.bus_address[15:12] == SELECT_PAGE);
    assign in_rom    = s1_item_reg.bus_address[15];
    assign wdata     = s1_item_reg.write_data;

    always_comb
    begin
        state_next      = state_reg;
        reg_select_next = reg_select_reg;
        if (s1_fire && is_write)
        begin
            // writes below 0x5000 and at 0x6000-0x7FFF fall through untouched
            if (in_select)
            begin
                // data bit 7 -> select bit 1, data bit 0 -> select bit 0
                reg_select_next = reg_sel_t'({wdata[7], wdata[0]});
            end
            else if (in_rom)
            begin
                unique case (reg_select_reg)
                    REG_CHR:
                    begin
                        state_next.chr_sel = wdata[1:0];
                        // one-screen page follows data bit 4
                        if (!state_reg.mirror[1])
                            state_next.mirror[0] = wdata[4];
                    end
                    REG_INNER:
                    begin
                        state_next.inner = wdata[3:0];
                        if (!state_reg.mirror[1])
                            state_next.mirror[0] = wdata[4];
                    end
                    REG_MODE:
                    begin
                        state_next.mode   = wdata[5:2];
                        state_next.mirror = wdata[1:0];
                    end
                    REG_OUTER:
                    begin
                        state_next.outer = wdata[5:0];
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            reg_select_reg <= REG_CHR;
        end
        else
        begin
            state_reg      <= state_next;
            reg_select_reg <= reg_select_next;
        end
    end

    // ---------------------------------------------------------------
    // Bank mixing on the post-access state
    // ---------------------------------------------------------------
    logic [PRG_BANK_W-1:0] mix_prg_low;
    logic [PRG_BANK_W-1:0] mix_prg_high;
    logic [CHR_BANK_W-1:0] mix_chr_bank;

    mcbm_bank_mix u_mix (
        .state    (state_next),
        .prg_mask (prg_mask_reg),
        .chr_mask (chr_mask_reg),
        .prg_low  (mix_prg_low),
        .prg_high (mix_prg_high),
        .chr_bank (mix_chr_bank)
    );

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_reg <= '{prg_bank_low:     mix_prg_low,
                         prg_bank_high:    mix_prg_high,
                         chr_bank:         mix_chr_bank,
                         mirror_mode:      state_next.mirror,
                         read_passthrough: !is_write && in_select};
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.prg_bank_low     = out_reg.prg_bank_low;
    assign res.prg_bank_high    = out_reg.prg_bank_high;
    assign res.chr_bank         = out_reg.chr_bank;
    assign res.mirror_mode      = out_reg.mirror_mode;
    assign res.read_passthrough = out_reg.read_passthrough;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !is_write) |=> ($stable(state_reg) && $stable(reg_select_reg)))
        else $error("read beat changed banking state");

    a_fixed_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && is_write && !in_select && in_rom && state_reg.mirror[1]
         && reg_select_reg != REG_MODE) |=> $stable(state_reg.mirror))
        else $error("mirroring changed outside mode register write");

    a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("accepted beat lost before result register");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> ($stable(state_reg) && $stable(reg_select_reg)))
        else $error("banking state changed without a beat");

endmodule

// File: tb/tb_multicart_bank_mapper.sv
module tb_multicart_bank_mapper;
    import mcbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index that maps to no register; a write there must leave the masks alone.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 8'd200;
    localparam int MAX_IDLE      = 14;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;

    logic clk;
    logic rst_n;

    mcbm_bus_if bus_if ();
    mcbm_res_if res_if ();
    mcbm_cfg_if cfg_if ();

    multicart_bank_mapper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bus   (bus_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // Shadow copy of the mapper: banking registers plus the two size masks.
    reg_sel_t        sel_q;
    logic [1:0]      mirror_q;
    logic [3:0]      inner_q;
    logic [3:0]      mode_q;
    logic [5:0]      outer_q;
    logic [1:0]      chr_q;
    logic [7:0]      prg_mask_q;
    logic [1:0]      chr_mask_q;

    result_t         bank_results_q[$];   // bank maps still owed by the block
    int              error_count = 0;
    int              beats_sent  = 0;
    bit              tx_idle_on  = 1'b1;  // sender inserts random gaps
    bit              rx_idle_on  = 1'b1;  // receiver inserts random stalls
    int              rx_hold_cycles = 0;  // one-shot long hold-off request

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, several times the slowest legal run.
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Bank mixing: outer bank supplies the high bits, inner bank the low
    // bits, the game size decides how many low bits come from inner.
    // In a fixed-bank mode the fixed window falls back to 32K mode.
    // ------------------------------------------------------------------
    function automatic logic [7:0] prg_window_bank(input logic a14);
        logic [7:0] outer2;
        logic [3:0] mode;
        logic [7:0] cur;
        logic [7:0] size_mask;
        outer2 = {1'b0, outer_q, 1'b0};
        mode   = mode_q;
        cur    = {4'b0, inner_q};
        if ((mode[1:0] ^ {1'b0, a14}) == 2'b10)
            mode = 4'd0;
        // 32K modes: inner selects a 32K bank, A14 picks the half
        if (!mode[1])
            cur = {3'b0, inner_q, a14};
        case (mode[3:2])
            2'd0:    size_mask = 8'h01;
            2'd1:    size_mask = 8'h03;
            2'd2:    size_mask = 8'h07;
            default: size_mask = 8'h0F;
        endcase
        return ((cur ^ outer2) & size_mask) ^ outer2;
    endfunction

    // Only banks past the ROM size get wrapped by the mask.
    function automatic logic [7:0] clamp_bank(input logic [7:0] bank, input logic [7:0] mask);
        return (bank > mask) ? (bank & mask) : bank;
    endfunction

    // One-screen select follows data bit 4 while mirroring is one-screen.
    function automatic void copy_one_screen(input logic [7:0] data);
        if (!mirror_q[1])
            mirror_q[0] = data[4];
    endfunction

    // Applies one bus beat to the shadow registers and returns the bank map.
    function automatic result_t map_access(input logic op, input logic [15:0] addr,
                                           input logic [7:0] data);
        result_t r;
        logic    in_select;
        in_select = (addr[15:12] == SELECT_PAGE);
        if (op == OP_WRITE) begin
            if (in_select)
                sel_q = reg_sel_t'({data[7], data[0]});
            else if (addr[15]) begin
                case (sel_q)
                    REG_CHR:
                    begin
                        copy_one_screen(data);
                        chr_q = data[1:0];
                    end
                    REG_INNER:
                    begin
                        inner_q = data[3:0];
                        copy_one_screen(data);
                    end
                    REG_MODE:
                    begin
                        mode_q   = data[5:2];
                        mirror_q = data[1:0];
                    end
                    default:
                        outer_q = data[5:0];
                endcase
            end
            // 0x0000-0x4FFF and 0x6000-0x7FFF: no register here
        end
        r.prg_bank_low     = clamp_bank(prg_window_bank(1'b0), prg_mask_q);
        r.prg_bank_high    = clamp_bank(prg_window_bank(1'b1), prg_mask_q);
        r.chr_bank         = clamp_bank({6'b0, chr_q}, {6'b0, chr_mask_q});
        r.mirror_mode      = mirror_q;
        r.read_passthrough = (op == OP_READ) && in_select;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bus sender: one beat per call. valid stays high into the next call
    // when no gap is drawn, so back-to-back beats need no re-raise.
    // ------------------------------------------------------------------
    task automatic send_access(input logic op, input logic [15:0] addr,
                               input logic [7:0] data);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge clk);
        if (gap != 0) begin
            bus_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        bus_if.valid       = 1'b1;
        bus_if.operation   = op;
        bus_if.bus_address = addr;
        bus_if.write_data  = data;
        @(posedge clk);
        while (!bus_if.ready)
            @(posedge clk);
        bank_results_q.push_back(map_access(op, addr, data));
        beats_sent++;
    endtask

    task automatic bus_idle();
        @(negedge clk);
        bus_if.valid = 1'b0;
    endtask

    // Waits for every owed result plus the pipeline depth.
    task automatic drain_results();
        while (bank_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg_reg(input logic [7:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = index;
        cfg_if.data  = value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (index == CFG_PRG_MASK)
            prg_mask_q = value;
        else if (index == CFG_CHR_MASK)
            chr_mask_q = value[1:0];
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: random stall before each beat, plus the one-shot
    // long hold-off, counted here in cycles.
    // ------------------------------------------------------------------
    task automatic check_field(input string label, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, label, exp_v, act_v);
            error_count++;
        end
    endtask

    initial begin
        int unsigned stall;
        int          hold;
        result_t     want;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                res_if.ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0) begin
                res_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready = 1'b1;
            do
                @(posedge clk);
            while (!res_if.valid);
            if (bank_results_q.size() == 0) begin
                $display("%0t: result beat with none expected, actual %0h %0h %0h %0h %0h",
                         $time, res_if.prg_bank_low, res_if.prg_bank_high,
                         res_if.chr_bank, res_if.mirror_mode, res_if.read_passthrough);
                error_count++;
            end
            else begin
                want = bank_results_q.pop_front();
                check_field("prg_bank_low", want.prg_bank_low, res_if.prg_bank_low);
                check_field("prg_bank_high", want.prg_bank_high, res_if.prg_bank_high);
                check_field("chr_bank", {6'b0, want.chr_bank}, {6'b0, res_if.chr_bank});
                check_field("mirror_mode", {6'b0, want.mirror_mode},
                            {6'b0, res_if.mirror_mode});
                check_field("read_passthrough", {7'b0, want.read_passthrough},
                            {7'b0, res_if.read_passthrough});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building blocks
    // ------------------------------------------------------------------

    // Well-formed update: select a register, load it from ROM space,
    // then a few reads anywhere to look at the new map.
    task automatic register_sequence();
        reg_sel_t   target;
        logic [7:0] sel_data;
        int         reads;
        target   = reg_sel_t'($urandom_range(0, 3));
        sel_data = 8'($urandom_range(0, 255));
        sel_data[7] = target[1];
        sel_data[0] = target[0];
        send_access(OP_WRITE, {SELECT_PAGE, 12'($urandom_range(0, 4095))}, sel_data);
        send_access(OP_WRITE, {1'b1, 15'($urandom_range(0, 32767))},
                    8'($urandom_range(0, 255)));
        reads = $urandom_range(0, 3);
        repeat (reads) begin
            if ($urandom_range(0, 3) == 0)
                send_access(OP_READ, {SELECT_PAGE, 12'($urandom_range(0, 4095))}, 8'($urandom));
            else
                send_access(OP_READ, 16'($urandom), 8'($urandom));
        end
    endtask

    // Any op, any address, any data: stray writes, bare selects, reads.
    task automatic noise_access();
        send_access(logic'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
    endtask

    // Mostly well-formed sequences with some noise; idling toggles now
    // and then so that stretches with no gaps appear on both sides.
    task automatic run_mix(input int n);
        int stop_at;
        stop_at = beats_sent + n;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 11) == 0) begin
                tx_idle_on = ($urandom_range(0, 2) != 0);
                rx_idle_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 4) == 0)
                noise_access();
            else
                register_sequence();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every register, fixed-bank mode, one-screen copy,
    // passthrough window edges, writes to unmapped space.
    task automatic test_directed_accesses();
        send_access(OP_READ,  16'h0000, 8'h00);   // reset map
        send_access(OP_READ,  16'hFFFF, 8'hFF);
        send_access(OP_READ,  16'h5000, 8'h00);   // passthrough, low edge
        send_access(OP_READ,  16'h5FFF, 8'hFF);   // passthrough, high edge
        send_access(OP_READ,  16'h4FFF, 8'h00);
        send_access(OP_READ,  16'h6000, 8'h00);
        send_access(OP_WRITE, 16'h5000, 8'h80);   // select mode register
        send_access(OP_WRITE, 16'h8000, 8'h3F);   // mode 15, horizontal
        send_access(OP_WRITE, 16'h5FFF, 8'h01);   // select inner
        send_access(OP_WRITE, 16'hFFFF, 8'h1F);   // no one-screen copy now
        send_access(OP_WRITE, 16'h5000, 8'h00);   // select CHR
        send_access(OP_WRITE, 16'hC000, 8'hFF);
        send_access(OP_WRITE, 16'h5000, 8'h80);
        send_access(OP_WRITE, 16'h8000, 8'h00);   // 32K mode, one-screen low
        send_access(OP_WRITE, 16'h5000, 8'h7E);   // bits 7 and 0 clear: CHR
        send_access(OP_WRITE, 16'h8000, 8'h12);   // one-screen copy of bit 4
        send_access(OP_WRITE, 16'h5000, 8'h81);   // select outer
        send_access(OP_WRITE, 16'hBFFF, 8'hFF);
        send_access(OP_WRITE, 16'h8000, 8'h00);
        send_access(OP_WRITE, 16'h4FFF, 8'hFF);   // unmapped writes
        send_access(OP_WRITE, 16'h6000, 8'hFF);
        send_access(OP_WRITE, 16'h7FFF, 8'h81);
        send_access(OP_WRITE, 16'h5000, 8'h80);
        send_access(OP_WRITE, 16'h8000, 8'h0A);   // fixed-bank mode, vertical
        send_access(OP_READ,  16'hC000, 8'h00);
    endtask

    // Mask settings from one extreme to the other, mixed traffic under each.
    task automatic test_mask_settings();
        logic [7:0] prg_set[6];
        logic [1:0] chr_set[6];
        prg_set = '{8'd255, 8'd0, 8'd7, 8'd15, 8'($urandom), 8'd127};
        chr_set = '{2'd3,   2'd0, 2'd1, 2'd2,  2'($urandom), 2'd3};
        foreach (prg_set[i]) begin
            bus_idle();
            drain_results();
            write_cfg_reg(CFG_PRG_MASK, prg_set[i]);
            write_cfg_reg(CFG_CHR_MASK, {6'($urandom), chr_set[i]});
            if (i == 2)
                write_cfg_reg(CFG_SPARE_INDEX, 8'($urandom));
            run_mix(200);
        end
    endtask

    // Long receiver hold-off while the sender keeps offering beats
    // back to back: the pipeline fills and the bus side must stall.
    task automatic test_output_stall();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        run_mix(100);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Sender stops mid-stream until the block has handed back everything.
    task automatic test_sender_pause();
        run_mix(50);
        bus_idle();
        drain_results();
        run_mix(50);
    endtask

    task automatic test_random_traffic();
        run_mix(450);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n              = 1'b0;
        bus_if.valid       = 1'b0;
        bus_if.operation   = OP_READ;
        bus_if.bus_address = '0;
        bus_if.write_data  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        sel_q      = REG_CHR;
        mirror_q   = STATE_RESET.mirror;
        inner_q    = STATE_RESET.inner;
        mode_q     = STATE_RESET.mode;
        outer_q    = STATE_RESET.outer;
        chr_q      = STATE_RESET.chr_sel;
        prg_mask_q = PRG_MASK_RESET;
        chr_mask_q = CHR_MASK_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_accesses();
        test_random_traffic();
        test_mask_settings();
        test_output_stall();
        test_sender_pause();

        bus_idle();
        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
sv/mcbm_pkg.sv
sv/mcbm_bus_if.sv
sv/mcbm_res_if.sv
sv/mcbm_cfg_if.sv
sv/mcbm_bank_mix.sv
sv/multicart_bank_mapper.sv
tb/tb_multicart_bank_mapper.sv
